[rtl/sand_slab_transport_step_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the sand slab transport step
// Shared overlapping-implication and next-cycle-implication property wrappers.
// ----------------------------------------------------------------------------
`ifndef SAND_SLAB_TRANSPORT_STEP_MACROS_SVH
`define SAND_SLAB_TRANSPORT_STEP_MACROS_SVH

`define SST_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sst assertion failed");

`define SST_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sst assertion failed");

`endif

[rtl/sst_pkg.sv]
// ----------------------------------------------------------------------------
// Sand slab transport package
// Codes, register indexes, sequencer states and neighbor offset tables.
// ----------------------------------------------------------------------------
`default_nettype none
package sst_pkg;

  typedef enum logic [1:0] {
    ACT_WRITE = 2'd0,
    ACT_READ  = 2'd1,
    ACT_MOVE  = 2'd2
  } action_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_EMPTY     = 3'd1,
    ST_HOP_LIMIT = 3'd2,
    ST_SLIDE_LIM = 3'd3,
    ST_SATURATED = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    CFG_SLAB_LAND  = 3'd0,
    CFG_FLOOR_LAND = 3'd1,
    CFG_HOP_LENGTH = 3'd2,
    CFG_REPOSE     = 3'd3,
    CFG_SEED       = 3'd4
  } cfg_index_t;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_WRITE, S_SRC_RD, S_SRC_CHK, S_NB_RD, S_NB_CHK, S_NB_WR,
    S_HOP, S_HOP_RD, S_HOP_CHK, S_SH_RD, S_SH_CHK, S_DEP, S_FIN_RD, S_DONE
  } state_t;

  localparam logic [15:0] SLAB_LAND_RESET  = 16'd39322;
  localparam logic [15:0] FLOOR_LAND_RESET = 16'd26214;
  localparam logic [4:0]  HOP_RESET        = 5'd5;
  localparam logic [3:0]  REPOSE_RESET     = 4'd2;
  localparam logic [15:0] SEED_RESET       = 16'd44257;
  localparam logic [15:0] LFSR_TAPS        = 16'hB400;
  localparam logic [7:0]  HEIGHT_MAX       = 8'd255;

  // Offset codes: 0 is minus one, 1 is none, 2 is plus one.
  localparam logic [1:0] NB_DX [8] = '{2'd0, 2'd2, 2'd1, 2'd1, 2'd0, 2'd2, 2'd0, 2'd2};
  localparam logic [1:0] NB_DY [8] = '{2'd1, 2'd1, 2'd0, 2'd2, 2'd0, 2'd0, 2'd2, 2'd2};

endpackage
`default_nettype wire

[rtl/sst_if.sv]
// ----------------------------------------------------------------------------
// Sand slab transport channels
// Request and response handshake interfaces with their payload fields.
// ----------------------------------------------------------------------------
`default_nettype none
interface sst_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] action;
  logic [5:0] cell_x;
  logic [5:0] cell_y;
  logic [7:0] height_in;
  modport source (output valid, action, cell_x, cell_y, height_in, input ready);
  modport sink (input valid, action, cell_x, cell_y, height_in, output ready);
endinterface

interface sst_rsp_if;
  logic       valid;
  logic       ready;
  logic [5:0] land_x;
  logic [5:0] land_y;
  logic [7:0] height_out;
  logic [2:0] status;
  modport source (output valid, land_x, land_y, height_out, status, input ready);
  modport sink (input valid, land_x, land_y, height_out, status, output ready);
endinterface
`default_nettype wire

[rtl/sst_lfsr.sv]
// ----------------------------------------------------------------------------
// Sand slab transport random source
// 16-bit Galois LFSR with seed load; a zero seed or zero step result gives one.
// ----------------------------------------------------------------------------
`default_nettype none
module sst_lfsr (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        load,
  input  wire logic [15:0] seed,
  input  wire logic        step,
  output logic      [15:0] value
);
  import sst_pkg::*;

  logic [15:0] value_next;
  logic [15:0] shifted;

  always_comb begin
    shifted = {1'b0, value[15:1]} ^ (value[0] ? LFSR_TAPS : 16'd0);
    value_next = value;
    if (load) begin
      value_next = (seed == 16'd0) ? 16'd1 : seed;
    end else if (step) begin
      value_next = (shifted == 16'd0) ? 16'd1 : shifted;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      value <= SEED_RESET;
    end else begin
      value <= value_next;
    end
  end
endmodule
`default_nettype wire

[rtl/sand_slab_transport_step.sv]
// ----------------------------------------------------------------------------
// Sand slab transport step
// Toroidal slab height grid with write, read and single-grain move actions.
// ----------------------------------------------------------------------------
// A move takes a grain from a non-empty source and lets the grid slide, then
// hops it along x until it lands, is shadowed or meets the hop limit, and
// deposits it unless the cell is saturated, sliding downhill after that.
// One item is in work at a time; the result register frees the input side.
// After reset a clearing pass zeroes the grid before any request is taken.
`default_nettype none
`include "sand_slab_transport_step_macros.svh"
module sand_slab_transport_step #(
  parameter int GRID_X       = 64,
  parameter int GRID_Y       = 64,
  parameter int MAX_HOPS     = 64,
  parameter int MAX_SLIDES   = 256,
  parameter int SHADOW_REACH = 5
) (
  input  wire logic        clk,
  input  wire logic        rst,
  sst_req_if.sink          req,
  sst_rsp_if.source        rsp,
  input  wire logic        write_enable,
  input  wire logic [2:0]  reg_index,
  input  wire logic [15:0] write_data
);
  import sst_pkg::*;

  localparam int XW    = $clog2(GRID_X);
  localparam int YW    = $clog2(GRID_Y);
  localparam int DEPTH = GRID_X * GRID_Y;
  localparam int AW    = $clog2(DEPTH);
  localparam int SLW   = $clog2(MAX_SLIDES + 1);
  localparam int HPW   = $clog2(MAX_HOPS + 1);
  localparam int SRW   = $clog2(SHADOW_REACH + 1);

  function automatic logic [XW-1:0] mod_x(input logic [XW+5:0] v);
    logic [XW+5:0] t;
    t = v;
    for (int i = 0; i < 8; i++) begin
      if (t >= (XW+6)'(GRID_X)) t = t - (XW+6)'(GRID_X);
    end
    return t[XW-1:0];
  endfunction

  function automatic logic [YW-1:0] mod_y(input logic [YW+5:0] v);
    logic [YW+5:0] t;
    t = v;
    for (int i = 0; i < 8; i++) begin
      if (t >= (YW+6)'(GRID_Y)) t = t - (YW+6)'(GRID_Y);
    end
    return t[YW-1:0];
  endfunction

  function automatic logic [XW-1:0] step_x(input logic [XW-1:0] v, input logic [1:0] d);
    logic [XW-1:0] r;
    r = v;
    if (d == 2'd0) r = (v == '0) ? XW'(GRID_X - 1) : v - XW'(1);
    if (d == 2'd2) r = (v == XW'(GRID_X - 1)) ? '0 : v + XW'(1);
    return r;
  endfunction

  function automatic logic [YW-1:0] step_y(input logic [YW-1:0] v, input logic [1:0] d);
    logic [YW-1:0] r;
    r = v;
    if (d == 2'd0) r = (v == '0) ? YW'(GRID_Y - 1) : v - YW'(1);
    if (d == 2'd2) r = (v == YW'(GRID_Y - 1)) ? '0 : v + YW'(1);
    return r;
  endfunction

  function automatic logic [AW-1:0] addr_of(input logic [XW-1:0] x, input logic [YW-1:0] y);
    return AW'(y) * AW'(GRID_X) + AW'(x);
  endfunction

  state_t state, state_next;

  logic [15:0] slab_chance, floor_chance;
  logic [4:0]  hop_len;
  logic [3:0]  repose;
  logic [15:0] rnd;
  logic        lfsr_step;

  logic [7:0] grid [DEPTH];
  logic [7:0] mem_q;
  logic       mem_we;
  logic [AW-1:0] mem_wa, mem_ra;
  logic [7:0] mem_wd;

  logic [1:0]    act;
  logic [XW-1:0] px, cur_x, nb_x, sh_x;
  logic [YW-1:0] py, cur_y, nb_y;
  logic [7:0]    hin, hout, hc, hn_new, hl;
  logic [2:0]    k;
  logic          downhill, slide_hit, hop_hit, sat;
  logic [SLW-1:0] slides;
  logic [HPW-1:0] hops;
  logic [SRW-1:0] sh_i;
  logic [AW-1:0]  clr_addr;
  logic           ov;
  logic [5:0]     o_x, o_y;
  logic [7:0]     o_h;
  logic [2:0]     o_st;

  logic [XW-1:0]  nbx_c;
  logic [YW-1:0]  nby_c;
  logic signed [9:0] diff;
  logic           breaks, land_ok, shadow_hit, slot_free;
  logic [XW+5:0]  px_wide;
  logic [YW+5:0]  py_wide;

  sst_lfsr u_lfsr (
    .clk   (clk),
    .rst   (rst),
    .load  (write_enable && (reg_index == CFG_SEED)),
    .seed  (write_data),
    .step  (lfsr_step),
    .value (rnd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      slab_chance  <= SLAB_LAND_RESET;
      floor_chance <= FLOOR_LAND_RESET;
      hop_len      <= HOP_RESET;
      repose       <= REPOSE_RESET;
    end else if (write_enable) begin
      case (reg_index)
        CFG_SLAB_LAND:  slab_chance <= write_data;
        CFG_FLOOR_LAND: floor_chance <= write_data;
        CFG_HOP_LENGTH: hop_len <= write_data[4:0];
        CFG_REPOSE:     repose <= write_data[3:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) grid[mem_wa] <= mem_wd;
    mem_q <= grid[mem_ra];
  end

  assign nbx_c = step_x(cur_x, NB_DX[k]);
  assign nby_c = step_y(cur_y, NB_DY[k]);
  assign diff = downhill ? ($signed({2'b0, hc}) - $signed({2'b0, mem_q}))
                         : ($signed({2'b0, mem_q}) - $signed({2'b0, hc}));
  assign breaks = diff > $signed({6'b0, repose});
  assign land_ok = ((mem_q != 8'd0) && (rnd < slab_chance)) ||
                   ((mem_q == 8'd0) && (rnd < floor_chance));
  assign shadow_hit = 10'(mem_q) > (10'(hl) + 10'(sh_i));
  assign slot_free = !ov || rsp.ready;
  assign px_wide = (XW+6)'(px);
  assign py_wide = (YW+6)'(py);

  always_comb begin
    state_next = state;
    mem_we = 1'b0;
    mem_wa = '0;
    mem_wd = '0;
    mem_ra = '0;
    lfsr_step = 1'b0;
    case (state)
      S_CLEAR: begin
        mem_we = 1'b1;
        mem_wa = clr_addr;
        if (clr_addr == AW'(DEPTH - 1)) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (req.valid) begin
          case (req.action)
            ACT_WRITE: state_next = S_WRITE;
            ACT_READ, ACT_MOVE: state_next = S_SRC_RD;
            default: state_next = S_DONE;
          endcase
        end
      end
      S_WRITE: begin
        mem_we = 1'b1;
        mem_wa = addr_of(px, py);
        mem_wd = hin;
        state_next = S_DONE;
      end
      S_SRC_RD: begin
        mem_ra = addr_of(px, py);
        state_next = S_SRC_CHK;
      end
      S_SRC_CHK: begin
        if (act == ACT_READ || downhill || mem_q == 8'd0) begin
          state_next = S_DONE;
        end else begin
          mem_we = 1'b1;
          mem_wa = addr_of(px, py);
          mem_wd = mem_q - 8'd1;
          state_next = S_NB_RD;
        end
      end
      S_NB_RD: begin
        mem_ra = addr_of(nbx_c, nby_c);
        state_next = S_NB_CHK;
      end
      S_NB_CHK: begin
        if (breaks && slides < SLW'(MAX_SLIDES)) begin
          mem_we = 1'b1;
          mem_wa = addr_of(cur_x, cur_y);
          mem_wd = downhill ? hc - 8'd1 : hc + 8'd1;
          state_next = S_NB_WR;
        end else if (breaks || k == 3'd7) begin
          state_next = downhill ? S_FIN_RD : S_HOP;
        end else begin
          state_next = S_NB_RD;
        end
      end
      S_NB_WR: begin
        mem_we = 1'b1;
        mem_wa = addr_of(nb_x, nb_y);
        mem_wd = hn_new;
        state_next = S_NB_RD;
      end
      S_HOP: begin
        if (hops == HPW'(MAX_HOPS)) begin
          state_next = S_DEP;
        end else begin
          lfsr_step = 1'b1;
          state_next = S_HOP_RD;
        end
      end
      S_HOP_RD: begin
        mem_ra = addr_of(px, py);
        state_next = S_HOP_CHK;
      end
      S_HOP_CHK: state_next = land_ok ? S_DEP : S_SH_RD;
      S_SH_RD: begin
        mem_ra = addr_of(sh_x, py);
        state_next = S_SH_CHK;
      end
      S_SH_CHK: begin
        if (shadow_hit) state_next = S_DEP;
        else if (sh_i == SRW'(SHADOW_REACH - 1)) state_next = S_HOP;
        else state_next = S_SH_RD;
      end
      S_DEP: begin
        if (hl == HEIGHT_MAX) begin
          state_next = S_DONE;
        end else begin
          mem_we = 1'b1;
          mem_wa = addr_of(px, py);
          mem_wd = hl + 8'd1;
          state_next = S_NB_RD;
        end
      end
      S_FIN_RD: begin
        mem_ra = addr_of(px, py);
        state_next = S_SRC_CHK;
      end
      S_DONE: begin
        if (slot_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clr_addr <= '0;
      ov <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_CLEAR) clr_addr <= clr_addr + AW'(1);
      if (state == S_DONE && slot_free) ov <= 1'b1;
      else if (rsp.ready) ov <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        act <= req.action;
        px <= mod_x((XW+6)'(req.cell_x));
        py <= mod_y((YW+6)'(req.cell_y));
        hin <= req.height_in;
        hout <= (req.action == ACT_WRITE) ? req.height_in : 8'd0;
        slides <= '0;
        slide_hit <= 1'b0;
        hop_hit <= 1'b0;
        sat <= 1'b0;
        hops <= '0;
        downhill <= 1'b0;
      end
      S_SRC_CHK: begin
        if (act == ACT_READ || downhill) begin
          hout <= mem_q;
        end else begin
          cur_x <= px;
          cur_y <= py;
          hc <= mem_q - 8'd1;
          k <= 3'd0;
        end
      end
      S_NB_RD: begin
        nb_x <= nbx_c;
        nb_y <= nby_c;
      end
      S_NB_CHK: begin
        hn_new <= downhill ? mem_q + 8'd1 : mem_q - 8'd1;
        if (breaks && slides >= SLW'(MAX_SLIDES)) slide_hit <= 1'b1;
        k <= k + 3'd1;
      end
      S_NB_WR: begin
        cur_x <= nb_x;
        cur_y <= nb_y;
        hc <= hn_new;
        slides <= slides + SLW'(1);
        k <= 3'd0;
      end
      S_HOP: begin
        if (hops == HPW'(MAX_HOPS)) begin
          hop_hit <= 1'b1;
        end else begin
          px <= mod_x(px_wide + (XW+6)'(hop_len));
          hops <= hops + HPW'(1);
        end
      end
      S_HOP_CHK: begin
        hl <= mem_q;
        sh_x <= step_x(px, 2'd0);
        sh_i <= '0;
      end
      S_SH_CHK: begin
        sh_x <= step_x(sh_x, 2'd0);
        sh_i <= sh_i + SRW'(1);
      end
      S_DEP: begin
        if (hl == HEIGHT_MAX) begin
          sat <= 1'b1;
          hout <= HEIGHT_MAX;
        end else begin
          cur_x <= px;
          cur_y <= py;
          hc <= hl + 8'd1;
          downhill <= 1'b1;
          k <= 3'd0;
        end
      end
      S_DONE: begin
        if (slot_free) begin
          o_x <= px_wide[5:0];
          o_y <= py_wide[5:0];
          o_h <= hout;
          if (act != ACT_MOVE) o_st <= ST_OK;
          else if (!downhill && !sat) o_st <= ST_EMPTY;
          else if (sat) o_st <= ST_SATURATED;
          else if (slide_hit) o_st <= ST_SLIDE_LIM;
          else if (hop_hit) o_st <= ST_HOP_LIMIT;
          else o_st <= ST_OK;
        end
      end
      default: ;
    endcase
  end

  assign req.ready      = (state == S_IDLE);
  assign rsp.valid      = ov;
  assign rsp.land_x     = o_x;
  assign rsp.land_y     = o_y;
  assign rsp.height_out = o_h;
  assign rsp.status     = o_st;

  `SST_ASSERT_IMPL(a_clear_blocks, state == S_CLEAR, !req.ready)
  `SST_ASSERT_IMPL(a_seed_nonzero, 1'b1, rnd != 16'd0)
  `SST_ASSERT_NEXT(a_slide_count, state == S_NB_WR, slides == $past(slides) + SLW'(1))
  `SST_ASSERT_NEXT(a_result_loads, state == S_DONE && slot_free, ov && state == S_IDLE)
endmodule
`default_nettype wire

[test/sand_slab_transport_step_tb.sv]
// ----------------------------------------------------------------------------
// Sand slab transport step testbench
// Drives write, read and move actions through the request channel, predicts
// each result with a behavioral model of the slab grid and the random
// landing draw, and compares every response transfer field by field. The
// hop length, repose, seed, landing chances and handshake pacing change by phase.
// ----------------------------------------------------------------------------
module sand_slab_transport_step_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import sst_pkg::*;

  localparam int GX = 64;
  localparam int GY = 64;
  localparam int HOP_CAP = 64;
  localparam int SLIDE_CAP = 256;
  localparam int SHADE = 5;
  localparam longint CYCLE_LIMIT = 40000000;

  typedef struct packed {
    logic [1:0] action;
    logic [5:0] x;
    logic [5:0] y;
    logic [7:0] h;
  } grain_req_t;

  typedef struct packed {
    logic [5:0] x;
    logic [5:0] y;
    logic [7:0] h;
    logic [2:0] status;
  } landing_t;

  logic clk;
  logic rst;
  logic write_enable;
  logic [2:0] reg_index;
  logic [15:0] write_data;

  sst_req_if req ();
  sst_rsp_if rsp ();

  sand_slab_transport_step DUT (
    .clk(clk), .rst(rst), .req(req.sink), .rsp(rsp.source),
    .write_enable(write_enable), .reg_index(reg_index), .write_data(write_data)
  );

  logic [7:0] grid_h [GX*GY];
  logic [15:0] lfsr_q;
  logic [15:0] slab_chance, floor_chance;
  logic [4:0] hop_len;
  logic [3:0] repose;

  grain_req_t pending_reqs [$];
  landing_t expected_landings [$];
  int idle_pct, stall_pct, hold_cycles;
  bit hold_rsp;
  int mismatches;
  longint cycles;

  function automatic int idx(int x, int y);
    return (y % GY) * GX + (x % GX);
  endfunction

  function automatic logic [15:0] step_lfsr();
    logic [15:0] s;
    s = {1'b0, lfsr_q[15:1]};
    if (lfsr_q[0]) s = s ^ 16'hB400;
    if (s == 16'd0) s = 16'd1;
    lfsr_q = s;
    return s;
  endfunction

  function automatic void slide(int x0, int y0, bit downhill, ref int slides,
                                ref bit hit);
    int x, y, k, tx, ty, d, fk, nx, ny, c;
    int dx [8] = '{-1, 1, 0, 0, -1, 1, -1, 1};
    int dy [8] = '{0, 0, -1, 1, -1, -1, 1, 1};
    x = x0;
    y = y0;
    forever begin
      fk = -1;
      c = idx(x, y);
      for (k = 0; k < 8 && fk < 0; k++) begin
        tx = (x + GX + dx[k]) % GX;
        ty = (y + GY + dy[k]) % GY;
        d = downhill ? int'(grid_h[c]) - int'(grid_h[idx(tx, ty)])
                     : int'(grid_h[idx(tx, ty)]) - int'(grid_h[c]);
        if (d > int'(repose)) begin
          fk = k;
          nx = tx;
          ny = ty;
        end
      end
      if (fk < 0) return;
      if (slides >= SLIDE_CAP) begin
        hit = 1;
        return;
      end
      if (downhill) begin
        grid_h[c]--;
        grid_h[idx(nx, ny)]++;
      end else begin
        grid_h[c]++;
        grid_h[idx(nx, ny)]--;
      end
      slides++;
      x = nx;
      y = ny;
    end
  endfunction

  function automatic bit in_shadow(int x, int y);
    int h, i;
    h = grid_h[idx(x, y)];
    for (i = 0; i < SHADE; i++) begin
      x = (x + GX - 1) % GX;
      if (int'(grid_h[idx(x, y)]) - h > i) return 1;
    end
    return 0;
  endfunction

  function automatic landing_t predict_landing(grain_req_t r);
    landing_t o;
    int x, y, slides, hop, c, h;
    bit slide_hit, hop_hit, sat;
    logic [15:0] draw;
    x = r.x;
    y = r.y;
    o = '0;
    if (r.action == ACT_WRITE) begin
      grid_h[idx(x, y)] = r.h;
      o.h = r.h;
    end else if (r.action == ACT_READ) begin
      o.h = grid_h[idx(x, y)];
    end else if (r.action == ACT_MOVE) begin
      if (grid_h[idx(x, y)] == 0) begin
        o.status = ST_EMPTY;
      end else begin
        slides = 0;
        slide_hit = 0;
        hop_hit = 1;
        sat = 0;
        grid_h[idx(x, y)]--;
        slide(x, y, 0, slides, slide_hit);
        for (hop = 0; hop < HOP_CAP && hop_hit; hop++) begin
          x = (x + hop_len) % GX;
          draw = step_lfsr();
          h = grid_h[idx(x, y)];
          if ((h > 0 && draw < slab_chance) || (h == 0 && draw < floor_chance) ||
              in_shadow(x, y))
            hop_hit = 0;
        end
        c = idx(x, y);
        if (grid_h[c] == HEIGHT_MAX) sat = 1;
        else begin
          grid_h[c]++;
          slide(x, y, 1, slides, slide_hit);
        end
        o.h = grid_h[c];
        o.status = sat ? ST_SATURATED : slide_hit ? ST_SLIDE_LIM :
                   hop_hit ? ST_HOP_LIMIT : ST_OK;
      end
    end
    o.x = x[5:0];
    o.y = y[5:0];
    return o;
  endfunction

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Request driver.
  always @(posedge clk) begin
    if (rst) begin
      req.valid <= 0;
    end else begin
      if (req.valid && req.ready) begin
        expected_landings.push_back(predict_landing(pending_reqs.pop_front()));
      end
      if (!req.valid || req.ready) begin
        if (pending_reqs.size() > 0 && $urandom_range(99) >= idle_pct) begin
          req.valid <= 1;
          req.action <= pending_reqs[0].action;
          req.cell_x <= pending_reqs[0].x;
          req.cell_y <= pending_reqs[0].y;
          req.height_in <= pending_reqs[0].h;
        end else begin
          req.valid <= 0;
        end
      end
    end
  end

  // Long receiver hold-off counter.
  always @(posedge clk) begin
    if (hold_cycles > 0) hold_cycles <= hold_cycles - 1;
  end

  // Response monitor.
  always @(posedge clk) begin
    landing_t got, exp_l;
    if (rst) begin
      rsp.ready <= 0;
    end else begin
      if (rsp.valid && rsp.ready) begin
        got = '{rsp.land_x, rsp.land_y, rsp.height_out, rsp.status};
        if (expected_landings.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %p", got);
        end else begin
          exp_l = expected_landings.pop_front();
          if (got !== exp_l) begin
            mismatches++;
            if (mismatches <= 10) $display("mismatch: expected %p actual %p", exp_l, got);
          end
        end
      end
      rsp.ready <= (hold_cycles == 0) && ($urandom_range(99) >= stall_pct);
    end
  end

  task automatic write_reg(cfg_index_t i, logic [15:0] v);
    @(posedge clk);
    write_enable <= 1;
    reg_index <= i;
    write_data <= v;
    case (i)
      CFG_SLAB_LAND: slab_chance = v;
      CFG_FLOOR_LAND: floor_chance = v;
      CFG_HOP_LENGTH: hop_len = v[4:0];
      CFG_REPOSE: repose = v[3:0];
      default: lfsr_q = (v == 0) ? 16'd1 : v;
    endcase
    @(posedge clk);
    write_enable <= 0;
  endtask

  task automatic drain();
    wait (pending_reqs.size() == 0 && !req.valid && expected_landings.size() == 0);
    repeat (20) @(posedge clk);
  endtask

  task automatic add_req(logic [1:0] a, int x, int y, int h);
    grain_req_t r;
    r.action = a;
    r.x = x;
    r.y = y;
    r.h = h;
    pending_reqs.push_back(r);
  endtask

  task automatic add_random(int n, int span);
    int i, x, y, k, bx, by;
    bx = $urandom_range(63);
    by = $urandom_range(63);
    for (i = 0; i < n; i++) begin
      x = (bx + $urandom_range(span)) % GX;
      y = (by + $urandom_range(span)) % GY;
      k = $urandom_range(99);
      if (k < 30) add_req(ACT_WRITE, x, y, ($urandom_range(9) == 0) ?
                          $urandom_range(255) : $urandom_range(12));
      else if (k < 45) add_req(ACT_READ, x, y, $urandom_range(255));
      else if (k < 97) add_req(ACT_MOVE, x, y, $urandom_range(255));
      else add_req(2'd3, $urandom_range(63), $urandom_range(63), $urandom_range(255));
    end
  endtask

  initial begin
    int p;
    rst = 1;
    write_enable = 0;
    reg_index = CFG_SLAB_LAND;
    write_data = 0;
    req.valid = 0;
    req.action = ACT_READ;
    req.cell_x = 0;
    req.cell_y = 0;
    req.height_in = 0;
    rsp.ready = 0;
    cycles = 0;
    mismatches = 0;
    hold_cycles = 0;
    idle_pct = 0;
    stall_pct = 0;
    foreach (grid_h[i]) grid_h[i] = 0;
    slab_chance = SLAB_LAND_RESET;
    floor_chance = FLOOR_LAND_RESET;
    hop_len = HOP_RESET;
    repose = REPOSE_RESET;
    lfsr_q = SEED_RESET;
    repeat (9) @(posedge clk);
    rst <= 0;

    // Directed: extremes, every action, empty source, hop limit.
    add_req(ACT_READ, 63, 63, 0);
    add_req(ACT_MOVE, 0, 0, 0);
    add_req(ACT_WRITE, 0, 0, 255);
    add_req(ACT_WRITE, 63, 63, 255);
    add_req(ACT_READ, 0, 0, 0);
    add_req(2'd3, 21, 42, 170);
    add_req(ACT_MOVE, 0, 0, 85);
    add_req(ACT_WRITE, 5, 63, 255);
    add_req(ACT_WRITE, 4, 63, 1);
    add_req(ACT_MOVE, 4, 63, 0);
    add_req(ACT_WRITE, 10, 10, 200);
    add_req(ACT_MOVE, 10, 10, 0);
    add_req(ACT_READ, 9, 10, 0);
    drain();
    write_reg(CFG_SLAB_LAND, 16'd0);
    write_reg(CFG_FLOOR_LAND, 16'd0);
    write_reg(CFG_HOP_LENGTH, 5'd0);
    write_reg(CFG_REPOSE, 4'd15);
    write_reg(CFG_SEED, 16'd0);
    add_req(ACT_WRITE, 30, 30, 3);
    add_req(ACT_MOVE, 30, 30, 0);
    add_req(ACT_MOVE, 30, 30, 0);
    add_req(ACT_WRITE, 33, 33, 255);
    add_req(ACT_MOVE, 33, 33, 0);
    drain();

    for (p = 0; p < 8; p++) begin
      case (p % 4)
        0: begin idle_pct = 0; stall_pct = 0; end
        1: begin idle_pct = 64; stall_pct = 0; end
        2: begin idle_pct = 0; stall_pct = 64; end
        default: begin idle_pct = 8; stall_pct = 8; end
      endcase
      write_reg(CFG_SLAB_LAND, (p == 7) ? 16'hFFFF : $urandom_range(65535));
      write_reg(CFG_FLOOR_LAND, (p == 6) ? 16'hFFFF : $urandom_range(65535));
      write_reg(CFG_HOP_LENGTH, (p == 5) ? 5'd31 : (p == 4) ? 5'd1 : $urandom_range(31));
      write_reg(CFG_REPOSE, (p == 3) ? 4'd0 : $urandom_range(15));
      write_reg(CFG_SEED, (p == 2) ? 16'hFFFF : $urandom_range(65535, 1));
      if (p == 1) hold_cycles = 400;
      add_random(220, (p % 2) ? 63 : 7);
      drain();
    end
    if (mismatches == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end
endmodule
